// ----- src/tmt_pkg.sv -----
// shared types, constants and op codes for the text mode terminal engine
`timescale 1ns / 1ps
`default_nettype none

package tmt_pkg;

    // screen geometry
    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLS;
    localparam int COPY_COUNT = CELL_COUNT - COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // field widths
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int POS_W   = 11;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = COLOR_W + CHAR_W;

    localparam int TAB_STEP = 8;

    localparam logic [CHAR_W-1:0]  SPACE_CHAR  = 8'h20;
    localparam logic [CHAR_W-1:0]  CHAR_BS     = 8'h08;
    localparam logic [CHAR_W-1:0]  CHAR_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0]  CHAR_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0]  CHAR_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0]  CHAR_LAST   = 8'h7F;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
    localparam logic [CELL_W-1:0]  RESET_CELL  = {RESET_COLOR, SPACE_CHAR};

    // func codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // decoded operation kinds
    localparam int OPK_W = 3;
    typedef logic [OPK_W-1:0] t_op_kind;

    localparam t_op_kind OP_NOP   = 3'd0;
    localparam t_op_kind OP_BS    = 3'd1;
    localparam t_op_kind OP_TAB   = 3'd2;
    localparam t_op_kind OP_CR    = 3'd3;
    localparam t_op_kind OP_LF    = 3'd4;
    localparam t_op_kind OP_PRINT = 3'd5;
    localparam t_op_kind OP_READ  = 3'd6;
    localparam t_op_kind OP_CLEAR = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } t_out_item;

    typedef struct packed {
        t_op_kind          kind;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
    } t_op;

endpackage

`default_nettype wire

// ----- src/text_mode_terminal_engine.sv -----
// top level of the text mode terminal engine
//
// A 25 x 80 character-cell console: each item puts one byte, reads one cell or clears
// the screen, and every item returns exactly one result with the cursor after it.
// Items pass through a two-entry queue to a single execution unit that owns the cursor
// and a one-write one-read screen memory, so items run one at a time. A read waits
// on a registered memory read. A scroll moves the screen up through the memory port
// one cell a cycle and then blanks the bottom row. A clear writes every cell. After
// reset the memory is swept to grey spaces with the input stalled; colour writes are
// taken throughout. The colour register should only be written with no item in
// flight.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_terminal_engine import tmt_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [COLOR_W-1:0] i_cfg_wr_data,
    input  wire logic               i_in_valid,
    input  wire t_in_item           i_in_item,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_item               o_out_item
);

    logic push;
    t_op  push_op;
    logic q_full;
    logic q_valid;
    t_op  q_op;
    logic pop;
    logic init;

    tmt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .i_hold     (init),
        .o_push     (push),
        .o_push_op  (push_op)
    );

    tmt_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_op      (q_op),
        .i_pop     (pop)
    );

    tmt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_q_op        (q_op),
        .o_pop         (pop),
        .o_init        (init),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

endmodule

`default_nettype wire

// ----- src/tmt_front.sv -----
// input side: accepts items and decodes them into operations
`timescale 1ns / 1ps
`default_nettype none

module tmt_front import tmt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_item,
    output logic          o_in_stall,
    input  wire logic     i_q_full,
    input  wire logic     i_hold,
    output logic          o_push,
    output t_op           o_push_op
);

    t_op_kind kind;

    always_comb begin
        kind = OP_NOP;
        unique case (i_in_item.func)
            FUNC_PUT: begin
                if (i_in_item.char_code == CHAR_BS) begin
                    kind = OP_BS;
                end else if (i_in_item.char_code == CHAR_TAB) begin
                    kind = OP_TAB;
                end else if (i_in_item.char_code == CHAR_CR) begin
                    kind = OP_CR;
                end else if (i_in_item.char_code == CHAR_LF) begin
                    kind = OP_LF;
                end else if (i_in_item.char_code >= SPACE_CHAR &&
                             i_in_item.char_code <= CHAR_LAST) begin
                    kind = OP_PRINT;
                end
            end
            FUNC_READ: begin
                // out-of-range reads report zero, same as a no-op
                if (i_in_item.cell_index < IDX_W'(CELL_COUNT)) begin
                    kind = OP_READ;
                end
            end
            FUNC_CLEAR: begin
                kind = OP_CLEAR;
            end
            default: begin
                kind = OP_NOP;
            end
        endcase
    end

    assign o_in_stall     = i_q_full | i_hold;
    assign o_push         = i_in_valid & ~o_in_stall;
    assign o_push_op.kind = kind;
    assign o_push_op.ch   = i_in_item.char_code;
    assign o_push_op.addr = ADDR_W'(i_in_item.cell_index);

    property p_no_push_on_stall;
        @(posedge i_clk) disable iff (!i_rst_n) o_in_stall |-> !o_push;
    endproperty
    a_no_push_on_stall: assert property (p_no_push_on_stall)
        else $error("push while input stalled");

endmodule

`default_nettype wire

// ----- src/tmt_queue.sv -----
// two-entry operation queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module tmt_queue import tmt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_push_op,
    output logic      o_full,
    output logic      o_valid,
    output t_op       o_op,
    input  wire logic i_pop
);

    t_op        r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_push_op;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_slot[r_rp];

    property p_no_pop_empty;
        @(posedge i_clk) disable iff (!i_rst_n) i_pop |-> r_cnt != 2'd0;
    endproperty
    a_no_pop_empty: assert property (p_no_pop_empty)
        else $error("pop from empty queue");

    property p_no_push_full;
        @(posedge i_clk) disable iff (!i_rst_n) i_push |-> r_cnt != 2'd2;
    endproperty
    a_no_push_full: assert property (p_no_push_full)
        else $error("push into full queue");

endmodule

`default_nettype wire

// ----- src/tmt_back.sv -----
// execution side: cursor rules, screen memory, scroll and clear sweeps
`timescale 1ns / 1ps
`default_nettype none

module tmt_back import tmt_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [COLOR_W-1:0] i_cfg_wr_data,
    input  wire logic               i_q_valid,
    input  wire t_op                i_q_op,
    output logic                    o_pop,
    output logic                    o_init,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_item               o_out_item
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;
    localparam logic [2:0] ST_RDWAIT = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ADDR_W-1:0]  r_cnt, n_cnt;
    logic               r_scr, n_scr;
    logic [COLOR_W-1:0] r_color;
    logic               r_out_valid;
    t_out_item          r_out_item, n_out_item;

    logic [CELL_W-1:0]  mem [CELL_COUNT];
    logic [CELL_W-1:0]  r_mem_q;

    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [CELL_W-1:0]  wr_data;

    logic               out_free;
    logic               done;
    logic [CELL_W-1:0]  done_data;
    logic               done_scr;
    logic [ADDR_W-1:0]  cur_addr;
    logic [CELL_W-1:0]  blank;

    logic [COL_W:0]     put_col;
    logic [ROW_W:0]     put_row;
    logic               put_scroll;

    assign out_free = ~r_out_valid | ~i_out_stall;
    assign cur_addr = ADDR_W'(r_row) * ADDR_W'(COLS) + ADDR_W'(r_col);
    assign blank    = {r_color, SPACE_CHAR};

    // cursor movement for one put operation
    always_comb begin
        put_col    = {1'b0, r_col};
        put_row    = {1'b0, r_row};
        put_scroll = 1'b0;
        case (i_q_op.kind)
            OP_BS: begin
                if (r_col != '0) begin
                    put_col = put_col - (COL_W+1)'(1);
                end
            end
            OP_TAB: begin
                put_col = (put_col + (COL_W+1)'(TAB_STEP)) & ~((COL_W+1)'(TAB_STEP - 1));
            end
            OP_CR: begin
                put_col = '0;
            end
            OP_LF: begin
                put_col = '0;
                put_row = put_row + (ROW_W+1)'(1);
            end
            OP_PRINT: begin
                put_col = put_col + (COL_W+1)'(1);
            end
            default: begin
            end
        endcase
        if (put_col >= (COL_W+1)'(COLS)) begin
            put_col = '0;
            put_row = put_row + (ROW_W+1)'(1);
        end
        if (put_row >= (ROW_W+1)'(ROWS)) begin
            put_scroll = 1'b1;
            put_row    = (ROW_W+1)'(ROWS - 1);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_cnt     = r_cnt;
        n_scr     = r_scr;
        o_pop     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_cnt;
        wr_data   = blank;
        rd_en     = 1'b0;
        rd_addr   = i_q_op.addr;
        done      = 1'b0;
        done_data = '0;
        done_scr  = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_data = RESET_CELL;
                if (r_cnt == ADDR_W'(CELL_COUNT - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    case (i_q_op.kind)
                        OP_NOP: begin
                            done = 1'b1;
                        end
                        OP_READ: begin
                            rd_en   = 1'b1;
                            n_state = ST_RDWAIT;
                        end
                        OP_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_cnt   = '0;
                            n_scr   = 1'b0;
                            n_state = ST_FILL;
                        end
                        default: begin
                            if (i_q_op.kind == OP_PRINT) begin
                                wr_en   = 1'b1;
                                wr_addr = cur_addr;
                                wr_data = {r_color, i_q_op.ch};
                            end
                            n_row = ROW_W'(put_row);
                            n_col = COL_W'(put_col);
                            if (put_scroll) begin
                                n_cnt   = '0;
                                n_scr   = 1'b1;
                                n_state = ST_SCROLL;
                            end else begin
                                done = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_RDWAIT: begin
                done      = 1'b1;
                done_data = r_mem_q;
                n_state   = ST_IDLE;
            end
            ST_SCROLL: begin
                // read one row down, write it back in the next cycle
                if (r_cnt < ADDR_W'(COPY_COUNT)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_cnt + ADDR_W'(COLS);
                end
                if (r_cnt != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = r_cnt - ADDR_W'(1);
                    wr_data = r_mem_q;
                end
                if (r_cnt == ADDR_W'(COPY_COUNT)) begin
                    n_state = ST_FILL;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            ST_FILL: begin
                wr_en = 1'b1;
                if (r_cnt == ADDR_W'(CELL_COUNT - 1)) begin
                    done     = 1'b1;
                    done_scr = r_scr;
                    n_cnt    = '0;
                    n_state  = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_item.cursor_row = n_row;
        n_out_item.cursor_col = n_col;
        n_out_item.cursor_pos = POS_W'(n_row) * POS_W'(COLS) + POS_W'(n_col);
        n_out_item.cell_data  = done_data;
        n_out_item.scrolled   = done_scr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_scr       <= 1'b0;
            r_color     <= RESET_COLOR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_cnt   <= n_cnt;
            r_scr   <= n_scr;
            if (i_cfg_wr_en) begin
                r_color <= i_cfg_wr_data;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    assign o_init      = (r_state == ST_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // a running sweep or read owns the output slot, which must be empty
    property p_busy_out_empty;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_state != ST_IDLE |-> !r_out_valid;
    endproperty
    a_busy_out_empty: assert property (p_busy_out_empty)
        else $error("result pending while a sweep runs");

    property p_cursor_range;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_row < ROW_W'(ROWS) && r_col < COL_W'(COLS);
    endproperty
    a_cursor_range: assert property (p_cursor_range)
        else $error("cursor off screen");

    property p_scroll_then_fill;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_state == ST_SCROLL |=> r_state == ST_SCROLL || r_state == ST_FILL;
    endproperty
    a_scroll_then_fill: assert property (p_scroll_then_fill)
        else $error("scroll left without blanking the bottom row");

endmodule

`default_nettype wire
